[sv/arm_alu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM ALU package
// Shared types and constants for the conditional integer/multiply ALU.
// ----------------------------------------------------------------------------
package arm_alu_pkg;

   localparam int WORD_BITS = 32;

   localparam logic [63:0] ROUND_CONST = 64'h0000_0000_8000_0000;

   typedef enum logic [3:0] {
      MODE_ADD   = 4'd0,
      MODE_ADC   = 4'd1,
      MODE_SUB   = 4'd2,
      MODE_SBC   = 4'd3,
      MODE_RSB   = 4'd4,
      MODE_CMP   = 4'd5,
      MODE_CMN   = 4'd6,
      MODE_TEQ   = 4'd7,
      MODE_MUL   = 4'd8,
      MODE_MLA   = 4'd9,
      MODE_SMULL = 4'd10,
      MODE_UMULL = 4'd11,
      MODE_SMMUL = 4'd12
   } mode_type;

   typedef enum logic [2:0] {
      SHIFT_LSL = 3'd0,
      SHIFT_LSR = 3'd1,
      SHIFT_ASR = 3'd2,
      SHIFT_ROR = 3'd3,
      SHIFT_RRX = 3'd4
   } shift_kind_type;

   // condition code pairs, selected by condition[3:1]; the low bit inverts
   typedef enum logic [2:0] {
      COND_EQ = 3'd0,
      COND_CS = 3'd1,
      COND_MI = 3'd2,
      COND_VS = 3'd3,
      COND_HI = 3'd4,
      COND_GE = 3'd5,
      COND_GT = 3'd6,
      COND_AL = 3'd7
   } cond_group_type;

   // flag bit positions inside NZCV
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 carry;
   } shift_out_type;

   typedef struct packed {
      logic                 passed;
      logic                 writes_result;
      logic [WORD_BITS-1:0] result_low;
      logic [WORD_BITS-1:0] result_high;
      logic [3:0]           flags;
   } exec_result_type;

endpackage

[sv/arm_alu_shift.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM ALU barrel shifter
// LSL, LSR, ASR, ROR and RRX on the second operand, with shifter carry out.
// ----------------------------------------------------------------------------
module arm_alu_shift (
   input  logic [31:0]                  operand,
   input  logic [2:0]                   shift_kind,
   input  logic [5:0]                   shift_amount,
   input  logic                         carry_in,
   output arm_alu_pkg::shift_out_type   shift_out
);
   import arm_alu_pkg::*;

   logic [63:0]        lsl_full;
   logic [63:0]        lsr_full;
   logic signed [63:0] asr_full;
   logic [63:0]        ror_full;
   shift_kind_type     kind;

   assign kind     = shift_kind_type'(shift_kind);
   assign lsl_full = {32'b0, operand} << shift_amount;
   assign lsr_full = {operand, 32'b0} >> shift_amount;
   assign asr_full = $signed({operand, 32'b0}) >>> shift_amount;
   // rotate uses the amount modulo 32
   assign ror_full = {operand, operand} >> shift_amount[4:0];

   always_comb begin
      shift_out.value = operand;
      shift_out.carry = carry_in;
      if (kind == SHIFT_RRX) begin
         shift_out.value = {carry_in, operand[31:1]};
         shift_out.carry = operand[0];
      end else if (shift_amount != 6'd0) begin
         case (kind)
            SHIFT_LSL: begin
               shift_out.value = lsl_full[31:0];
               shift_out.carry = lsl_full[32];
            end
            SHIFT_LSR: begin
               shift_out.value = lsr_full[63:32];
               shift_out.carry = lsr_full[31];
            end
            SHIFT_ASR: begin
               shift_out.value = asr_full[63:32];
               shift_out.carry = asr_full[31];
            end
            SHIFT_ROR: begin
               shift_out.value = ror_full[31:0];
               shift_out.carry = ror_full[31];
            end
            default: begin
               // unused kinds pass the operand with the stored carry
               shift_out.value = operand;
               shift_out.carry = carry_in;
            end
         endcase
      end
   end

endmodule

[sv/arm_alu_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM ALU execute logic
// Condition test, add/subtract forms, TEQ and multiplies with NZCV update.
// ----------------------------------------------------------------------------
module arm_alu_exec (
   input  logic [3:0]                    mode,
   input  logic [3:0]                    condition,
   input  logic [31:0]                   operand_a,
   input  logic [31:0]                   operand_b,
   input  logic [31:0]                   addend,
   input  logic                          set_flags,
   input  logic                          round_high,
   input  logic [3:0]                    flags,
   input  arm_alu_pkg::shift_out_type    shift_out,
   output arm_alu_pkg::exec_result_type  result
);
   import arm_alu_pkg::*;

   mode_type           op;
   cond_group_type     cond_group;
   logic               cond_raw;
   logic               cond_ok;
   logic               flag_n;
   logic               flag_z;
   logic               flag_c;
   logic               flag_v;
   logic [31:0]        add_x;
   logic [31:0]        add_y;
   logic               add_cin;
   logic [32:0]        add_sum;
   logic [3:0]         add_flags;
   logic [31:0]        teq_value;
   logic               mul_signed;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_full;
   logic [63:0]        prod;
   logic [31:0]        mla_value;
   logic [63:0]        smmul_value;

   assign op         = mode_type'(mode);
   assign cond_group = cond_group_type'(condition[3:1]);
   assign flag_n     = flags[FLAG_N];
   assign flag_z     = flags[FLAG_Z];
   assign flag_c     = flags[FLAG_C];
   assign flag_v     = flags[FLAG_V];

   always_comb begin
      unique case (cond_group)
         COND_EQ: cond_raw = flag_z;
         COND_CS: cond_raw = flag_c;
         COND_MI: cond_raw = flag_n;
         COND_VS: cond_raw = flag_v;
         COND_HI: cond_raw = flag_c & ~flag_z;
         COND_GE: cond_raw = (flag_n == flag_v);
         COND_GT: cond_raw = ~flag_z & (flag_n == flag_v);
         default: cond_raw = 1'b1;
      endcase
   end

   // always-group passes for both encodings
   assign cond_ok = (cond_group == COND_AL) ? 1'b1 : (cond_raw ^ condition[0]);

   always_comb begin
      add_x   = operand_a;
      add_y   = shift_out.value;
      add_cin = 1'b0;
      case (op) inside
         MODE_ADC:            add_cin = flag_c;
         MODE_SUB, MODE_CMP: begin
            add_y   = ~shift_out.value;
            add_cin = 1'b1;
         end
         MODE_SBC: begin
            add_y   = ~shift_out.value;
            add_cin = flag_c;
         end
         MODE_RSB: begin
            add_x   = ~operand_a;
            add_cin = 1'b1;
         end
         default: add_cin = 1'b0;
      endcase
   end

   assign add_sum   = {1'b0, add_x} + {1'b0, add_y} + {32'b0, add_cin};
   assign add_flags = {add_sum[31], (add_sum[31:0] == 32'b0), add_sum[32],
                       ((add_x[31] ^ add_sum[31]) & (add_y[31] ^ add_sum[31]))};

   assign teq_value = operand_a ^ shift_out.value;

   // one 33x33 signed multiplier serves signed and unsigned products
   assign mul_signed  = (op == MODE_SMULL) || (op == MODE_SMMUL);
   assign mul_a       = $signed({mul_signed & operand_a[31], operand_a});
   assign mul_b       = $signed({mul_signed & operand_b[31], operand_b});
   assign prod_full   = mul_a * mul_b;
   assign prod        = prod_full[63:0];
   assign mla_value   = prod[31:0] + ((op == MODE_MLA) ? addend : 32'b0);
   assign smmul_value = prod + (round_high ? ROUND_CONST : 64'b0);

   always_comb begin
      result       = '0;
      result.flags = flags;
      if (cond_ok) begin
         unique case (op) inside
            MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC, MODE_RSB: begin
               result.passed        = 1'b1;
               result.writes_result = 1'b1;
               result.result_low    = add_sum[31:0];
               if (set_flags) begin
                  result.flags = add_flags;
               end
            end
            MODE_CMP, MODE_CMN: begin
               result.passed = 1'b1;
               result.flags  = add_flags;
            end
            MODE_TEQ: begin
               result.passed = 1'b1;
               result.flags  = {teq_value[31], (teq_value == 32'b0), shift_out.carry, flag_v};
            end
            MODE_MUL, MODE_MLA: begin
               result.passed        = 1'b1;
               result.writes_result = 1'b1;
               result.result_low    = mla_value;
               if (set_flags) begin
                  result.flags = {mla_value[31], (mla_value == 32'b0), flag_c, flag_v};
               end
            end
            MODE_SMULL, MODE_UMULL: begin
               result.passed        = 1'b1;
               result.writes_result = 1'b1;
               result.result_low    = prod[31:0];
               result.result_high   = prod[63:32];
               if (set_flags) begin
                  result.flags = {prod[63], (prod == 64'b0), flag_c, flag_v};
               end
            end
            MODE_SMMUL: begin
               result.passed        = 1'b1;
               result.writes_result = 1'b1;
               result.result_low    = smmul_value[63:32];
            end
            default: begin
               // unused modes do nothing
               result.passed = 1'b0;
            end
         endcase
      end
   end

endmodule

[sv/arm_arith_multiply_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARM arithmetic and multiply ALU
// Conditional ARMv7-A add/subtract/compare/multiply step with NZCV flags.
//
//   channel | direction | handshake             | beat carries
//   req_    | in        | req_valid / req_stall | mode, condition, operands, shift
//   rsp_    | out       | rsp_valid / rsp_stall | passed, writes, results, flags
//
// One instruction per cycle sustained while rsp_stall is low. A beat fills
// an input register; shifter, adder and multiplier feed the result register,
// which drives rsp_valid. The flag register updates as a result is loaded, so
// the next instruction tests the flags of the one before it. Synchronous reset
// clears the flags and both valid bits. A stalled result holds; the input
// register keeps accepting while the result register is free or being taken.
// ----------------------------------------------------------------------------
module arm_arith_multiply_alu_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_mode,
   input  logic [3:0]  req_condition,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_addend,
   input  logic [2:0]  req_shift_kind,
   input  logic [5:0]  req_shift_amount,
   input  logic        req_set_flags,
   input  logic        req_round_high,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_passed,
   output logic        rsp_writes_result,
   output logic [31:0] rsp_result_low,
   output logic [31:0] rsp_result_high,
   output logic [3:0]  rsp_flags_out
);
   import arm_alu_pkg::*;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic [3:0]      mode_ff;
   logic [3:0]      condition_ff;
   logic [31:0]     operand_a_ff;
   logic [31:0]     operand_b_ff;
   logic [31:0]     addend_ff;
   logic [2:0]      shift_kind_ff;
   logic [5:0]      shift_amount_ff;
   logic            set_flags_ff;
   logic            round_high_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   exec_result_type rsp_ff;
   logic [3:0]      flags_ff;
   logic [3:0]      flags_in;
   logic            req_fire;
   logic            s1_move;
   logic            s1_fire;
   shift_out_type   shift_out;
   exec_result_type exec_result;

   assign s1_move     = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire     = s1_valid_ff & s1_move;
   assign req_stall   = s1_valid_ff & ~s1_move;
   assign req_fire    = req_valid & ~req_stall;
   assign s1_valid_in = req_fire | (s1_valid_ff & ~s1_move);
   assign rsp_valid_in = s1_fire | (rsp_valid_ff & rsp_stall);
   assign flags_in    = s1_fire ? exec_result.flags : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= 4'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff         <= req_mode;
         condition_ff    <= req_condition;
         operand_a_ff    <= req_operand_a;
         operand_b_ff    <= req_operand_b;
         addend_ff       <= req_addend;
         shift_kind_ff   <= req_shift_kind;
         shift_amount_ff <= req_shift_amount;
         set_flags_ff    <= req_set_flags;
         round_high_ff   <= req_round_high;
      end
      if (s1_fire) begin
         rsp_ff <= exec_result;
      end
   end

   arm_alu_shift u_shift (
      .operand      (operand_b_ff),
      .shift_kind   (shift_kind_ff),
      .shift_amount (shift_amount_ff),
      .carry_in     (flags_ff[FLAG_C]),
      .shift_out    (shift_out)
   );

   arm_alu_exec u_exec (
      .mode       (mode_ff),
      .condition  (condition_ff),
      .operand_a  (operand_a_ff),
      .operand_b  (operand_b_ff),
      .addend     (addend_ff),
      .set_flags  (set_flags_ff),
      .round_high (round_high_ff),
      .flags      (flags_ff),
      .shift_out  (shift_out),
      .result     (exec_result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_passed        = rsp_ff.passed;
   assign rsp_writes_result = rsp_ff.writes_result;
   assign rsp_result_low    = rsp_ff.result_low;
   assign rsp_result_high   = rsp_ff.result_high;
   assign rsp_flags_out     = rsp_ff.flags;

   // while a result is pending, the flag register mirrors its flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (flags_ff == rsp_ff.flags))
      else $error("flag register differs from pending result flags");

   // a skipped instruction writes nothing and returns zero words
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.passed) |->
         (!rsp_ff.writes_result && rsp_ff.result_low == 32'b0 &&
          rsp_ff.result_high == 32'b0))
      else $error("failed condition produced a result");

   // stall the request side only while the input register holds a beat
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input register");

   // flags move only when an instruction completes
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(flags_ff))
      else $error("flags changed without a completed instruction");

endmodule
